FILE: rtl/shd_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the string hash dictionary.
// No dependencies.
package shd_pkg;

    localparam int MOD_BITS = 16;   // dividend width of the serial modulo unit

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_TOO_LONG  = 3'd3;
    localparam logic [2:0] ST_FOUND     = 3'd4;
    localparam logic [2:0] ST_ABSENT    = 3'd5;

    localparam logic CFG_MODULUS    = 1'b0;
    localparam logic CFG_MULTIPLIER = 1'b1;

    typedef enum logic [2:0] {
        MS_POW   = 3'd0,
        MS_TERM  = 3'd1,
        MS_HASH  = 3'd2,
        MS_MULT  = 3'd3,
        MS_POW2  = 3'd4
    } t_msel;

    typedef struct packed {
        logic       clr_wr;
        logic       latch;
        logic       mod_load;
        t_msel      msel;
        logic       save_pm;
        logic       save_term;
        logic       save_hash;
        logic       save_pow;
        logic       fill_save;
        logic       s_clr;
        logic       s_inc;
        logic       k_clr;
        logic       k_inc;
        logic       ins_wr;
        logic       ins_fin;
        logic       out_en;
        logic       out_slot0;
        logic [2:0] out_status;
        logic       word_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic mod_done;
        logic last;
        logic kind;
        logic too_long;
        logic slot_end;
        logic fill_full;
        logic len_eq;
        logic k_end;
        logic chars_eq;
    } t_dp_stat;

endpackage

FILE: rtl/shd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module shd_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_raddr,
    input  logic [W-1:0]  i_wdata,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/shd_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the dictionary: hash steps, bucket search and insert.
// Depends on shd_pkg.
module shd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  shd_pkg::t_dp_stat i_stat,
    output shd_pkg::t_dp_cmd  o_cmd
);
    import shd_pkg::*;

    typedef enum logic [14:0] {
        S_CLR  = 15'h0001,
        S_IDLE = 15'h0002,
        S_PM   = 15'h0004,
        S_TM   = 15'h0008,
        S_HS   = 15'h0010,
        S_MM   = 15'h0020,
        S_PW   = 15'h0040,
        S_FRD  = 15'h0080,
        S_FWT  = 15'h0100,
        S_SLOT = 15'h0200,
        S_LWT  = 15'h0400,
        S_CRD  = 15'h0800,
        S_CWT  = 15'h1000,
        S_IRD  = 15'h2000,
        S_IWT  = 15'h4000
    } t_state;

    t_state r_state, n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch    = 1'b1;
                    o_cmd.mod_load = 1'b1;
                    o_cmd.msel     = MS_POW;
                    n_state        = S_PM;
                end
            end
            S_PM: begin
                if (i_stat.mod_done) begin
                    o_cmd.save_pm  = 1'b1;
                    o_cmd.mod_load = 1'b1;
                    o_cmd.msel     = MS_TERM;
                    n_state        = S_TM;
                end
            end
            S_TM: begin
                if (i_stat.mod_done) begin
                    o_cmd.save_term = 1'b1;
                    o_cmd.mod_load  = 1'b1;
                    o_cmd.msel      = MS_HASH;
                    n_state         = S_HS;
                end
            end
            S_HS: begin
                if (i_stat.mod_done) begin
                    o_cmd.save_hash = 1'b1;
                    o_cmd.mod_load  = 1'b1;
                    o_cmd.msel      = MS_MULT;
                    n_state         = S_MM;
                end
            end
            S_MM: begin
                if (i_stat.mod_done) begin
                    o_cmd.mod_load = 1'b1;
                    o_cmd.msel     = MS_POW2;
                    n_state        = S_PW;
                end
            end
            S_PW: begin
                if (i_stat.mod_done) begin
                    o_cmd.save_pow = 1'b1;
                    priority if (!i_stat.last) begin
                        n_state = S_IDLE;
                    end else if (i_stat.too_long) begin
                        o_cmd.out_en     = 1'b1;
                        o_cmd.out_slot0  = 1'b1;
                        o_cmd.out_status = ST_TOO_LONG;
                        o_cmd.word_clr   = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_state = S_FRD;
                    end
                end
            end
            S_FRD: n_state = S_FWT;
            S_FWT: begin
                o_cmd.fill_save = 1'b1;
                o_cmd.s_clr     = 1'b1;
                n_state         = S_SLOT;
            end
            S_SLOT: begin
                o_cmd.k_clr = 1'b1;
                priority if (!i_stat.slot_end) begin
                    n_state = S_LWT;
                end else if (i_stat.kind) begin
                    o_cmd.out_en     = 1'b1;
                    o_cmd.out_slot0  = 1'b1;
                    o_cmd.out_status = ST_ABSENT;
                    o_cmd.word_clr   = 1'b1;
                    n_state          = S_IDLE;
                end else if (i_stat.fill_full) begin
                    o_cmd.out_en     = 1'b1;
                    o_cmd.out_slot0  = 1'b1;
                    o_cmd.out_status = ST_FULL;
                    o_cmd.word_clr   = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_IRD;
                end
            end
            S_LWT: begin
                if (i_stat.len_eq) begin
                    n_state = S_CRD;
                end else begin
                    o_cmd.s_inc = 1'b1;
                    n_state     = S_SLOT;
                end
            end
            S_CRD: begin
                if (i_stat.k_end) begin
                    o_cmd.out_en     = 1'b1;
                    o_cmd.out_status = i_stat.kind ? ST_FOUND : ST_DUPLICATE;
                    o_cmd.word_clr   = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_CWT;
                end
            end
            S_CWT: begin
                if (i_stat.chars_eq) begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_CRD;
                end else begin
                    o_cmd.s_inc = 1'b1;
                    n_state     = S_SLOT;
                end
            end
            S_IRD: begin
                if (i_stat.k_end) begin
                    o_cmd.ins_fin    = 1'b1;
                    o_cmd.out_en     = 1'b1;
                    o_cmd.out_status = ST_INSERTED;
                    o_cmd.word_clr   = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_IWT;
                end
            end
            S_IWT: begin
                o_cmd.ins_wr = 1'b1;
                o_cmd.k_inc  = 1'b1;
                n_state      = S_IRD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

FILE: rtl/shd_dp.sv
`timescale 1ns / 1ps
// Datapath: config registers, serial modulo unit, word buffer and dictionary stores.
// Depends on shd_pkg and shd_ram.
module shd_dp #(
    parameter int NUM_BUCKETS  = 256,
    parameter int BUCKET_SLOTS = 8,
    parameter int MAX_WORD_LEN = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_kind,
    input  logic [7:0]        i_char_code,
    input  logic              i_last_char,
    input  shd_pkg::t_dp_cmd  i_cmd,
    output shd_pkg::t_dp_stat o_stat,
    output logic              o_valid,
    output logic [2:0]        o_status,
    output logic [7:0]        o_bucket,
    output logic [2:0]        o_slot
);
    import shd_pkg::*;

    localparam int LIM = (NUM_BUCKETS < 256) ? NUM_BUCKETS : 256;
    localparam int BAW = $clog2(NUM_BUCKETS);
    localparam int NE  = NUM_BUCKETS * BUCKET_SLOTS;
    localparam int NC  = NE * MAX_WORD_LEN;
    localparam int EAW = (NE > 1) ? $clog2(NE) : 1;
    localparam int CAW = (NC > 1) ? $clog2(NC) : 1;
    localparam int LW  = $clog2(MAX_WORD_LEN + 2);
    localparam int KW  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int FW  = $clog2(BUCKET_SLOTS + 1);
    localparam int MCW = $clog2(MOD_BITS + 1);

    logic [8:0]  r_modulus;
    logic [15:0] r_mult;
    logic [8:0]  p;

    logic          r_kind, r_last;
    logic [7:0]    r_ch;
    logic [LW-1:0] r_len;
    logic [7:0]    r_hash, r_pow, r_pm, r_term;

    logic [MOD_BITS-1:0] r_div, n_div;
    logic [7:0]          r_rem;
    logic [MCW-1:0]      r_mcnt;
    logic [8:0]          t9, hsum;

    logic [BAW-1:0] r_clr;
    logic [FW-1:0]  r_fill, r_s;
    logic [LW-1:0]  r_k;
    logic [EAW-1:0] e_addr;
    logic [CAW-1:0] c_addr;

    logic [FW-1:0] fill_rd, fill_wd;
    logic [BAW-1:0] fill_addr;
    logic [LW-1:0] len_rd;
    logic [7:0]    word_rd, store_rd;

    // effective modulus: 0 acts as 1, clipped to bucket count
    always_comb begin
        priority if (r_modulus == 9'd0) p = 9'd1;
        else if (r_modulus > 9'(LIM)) p = 9'(LIM);
        else p = r_modulus;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= 9'd251;
            r_mult    <= 16'd31;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODULUS:    r_modulus <= i_cfg_data[8:0];
                CFG_MULTIPLIER: r_mult    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // serial restoring modulo, one dividend bit per cycle
    always_comb begin
        unique case (i_cmd.msel)
            MS_POW:  n_div = {8'd0, r_pow};
            MS_TERM: n_div = MOD_BITS'(r_ch) * MOD_BITS'(r_rem);
            MS_HASH: n_div = {8'd0, r_hash};
            MS_MULT: n_div = r_mult;
            MS_POW2: n_div = MOD_BITS'(r_pm) * MOD_BITS'(r_rem);
            default: n_div = '0;
        endcase
    end

    assign t9   = {r_rem, r_div[MOD_BITS-1]};
    assign hsum = {1'b0, r_rem} + {1'b0, r_term};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= MCW'(MOD_BITS);
        end else if (i_cmd.mod_load) begin
            r_mcnt <= '0;
        end else if (r_mcnt != MCW'(MOD_BITS)) begin
            r_mcnt <= r_mcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_load) begin
            r_div <= n_div;
            r_rem <= '0;
        end else if (r_mcnt != MCW'(MOD_BITS)) begin
            r_div <= {r_div[MOD_BITS-2:0], 1'b0};
            r_rem <= (t9 >= p) ? 8'(t9 - p) : t9[7:0];
        end
    end

    // word state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_hash <= '0;
            r_pow  <= 8'd1;
        end else begin
            if (i_cmd.latch && (r_len <= LW'(MAX_WORD_LEN))) r_len <= r_len + 1'b1;
            if (i_cmd.save_hash) r_hash <= (hsum >= p) ? 8'(hsum - p) : hsum[7:0];
            if (i_cmd.save_pow) r_pow <= r_rem;
            if (i_cmd.word_clr) begin
                r_len  <= '0;
                r_hash <= '0;
                r_pow  <= 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= i_kind;
            r_ch   <= i_char_code;
            r_last <= i_last_char;
        end
        if (i_cmd.save_pm) r_pm <= r_rem;
        if (i_cmd.save_term) r_term <= r_rem;
        if (i_cmd.fill_save) r_fill <= fill_rd;
        if (i_cmd.s_clr) r_s <= '0;
        else if (i_cmd.s_inc) r_s <= r_s + 1'b1;
        if (i_cmd.k_clr) r_k <= '0;
        else if (i_cmd.k_inc) r_k <= r_k + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    assign e_addr    = EAW'(EAW'(r_hash) * EAW'(BUCKET_SLOTS) + EAW'(r_s));
    assign c_addr    = CAW'(CAW'(e_addr) * CAW'(MAX_WORD_LEN) + CAW'(r_k));
    assign fill_addr = i_cmd.clr_wr ? r_clr : BAW'(r_hash);
    assign fill_wd   = i_cmd.clr_wr ? '0 : FW'(r_fill + 1'b1);

    shd_ram #(.W(FW), .D(NUM_BUCKETS)) u_fill (
        .i_clk(i_clk), .i_we(i_cmd.clr_wr | i_cmd.ins_fin),
        .i_waddr(fill_addr), .i_raddr(fill_addr),
        .i_wdata(fill_wd), .o_rdata(fill_rd)
    );

    shd_ram #(.W(8), .D(MAX_WORD_LEN)) u_word (
        .i_clk(i_clk),
        .i_we(i_cmd.latch && (r_len < LW'(MAX_WORD_LEN))),
        .i_waddr(r_len[KW-1:0]), .i_raddr(r_k[KW-1:0]),
        .i_wdata(i_char_code), .o_rdata(word_rd)
    );

    shd_ram #(.W(LW), .D(NE)) u_len (
        .i_clk(i_clk), .i_we(i_cmd.ins_fin),
        .i_waddr(e_addr), .i_raddr(e_addr),
        .i_wdata(r_len), .o_rdata(len_rd)
    );

    shd_ram #(.W(8), .D(NC)) u_chars (
        .i_clk(i_clk), .i_we(i_cmd.ins_wr),
        .i_waddr(c_addr), .i_raddr(c_addr),
        .i_wdata(word_rd), .o_rdata(store_rd)
    );

    always_comb begin
        o_stat.clr_last  = (r_clr == BAW'(NUM_BUCKETS - 1));
        o_stat.mod_done  = (r_mcnt == MCW'(MOD_BITS));
        o_stat.last      = r_last;
        o_stat.kind      = r_kind;
        o_stat.too_long  = (r_len > LW'(MAX_WORD_LEN));
        o_stat.slot_end  = (r_s == r_fill);
        o_stat.fill_full = (r_fill >= FW'(BUCKET_SLOTS));
        o_stat.len_eq    = (len_rd == r_len);
        o_stat.k_end     = (r_k == r_len);
        o_stat.chars_eq  = (word_rd == store_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.out_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_en) begin
            o_status <= i_cmd.out_status;
            o_bucket <= r_hash;
            o_slot   <= i_cmd.out_slot0 ? 3'd0 : 3'(r_s);
        end
    end
endmodule

FILE: rtl/string_hash_dictionary_core.sv
`timescale 1ns / 1ps
// Top level of the string hash dictionary: sequencer plus datapath.
// Depends on shd_pkg, shd_ctrl, shd_dp (and shd_ram through shd_dp).
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+------------------------
//  input   | i_kind, i_char_code, i_last_char       | start & !busy
//  result  | o_status, o_bucket, o_slot             | o_valid, one cycle
//  config  | i_cfg_idx, i_cfg_data                  | i_cfg_we
//
// Each character word makes five 16-bit serial modulo passes through the one
// shared modulo unit. A last character then searches the slots of its bucket,
// comparing stored characters, and on insert stores the word's characters; a
// word that is too long ends without a search. After reset the bucket fill
// store is cleared with busy high. Results cannot be stalled; o_valid lasts
// one cycle.
module string_hash_dictionary_core #(
    parameter int NUM_BUCKETS  = 256,
    parameter int BUCKET_SLOTS = 8,
    parameter int MAX_WORD_LEN = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [7:0]  o_bucket,
    output logic [2:0]  o_slot
);
    import shd_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    shd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .start(start), .busy(busy),
        .i_stat(stat), .o_cmd(cmd)
    );

    shd_dp #(
        .NUM_BUCKETS(NUM_BUCKETS), .BUCKET_SLOTS(BUCKET_SLOTS),
        .MAX_WORD_LEN(MAX_WORD_LEN)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_kind(i_kind), .i_char_code(i_char_code), .i_last_char(i_last_char),
        .i_cmd(cmd), .o_stat(stat),
        .o_valid(o_valid), .o_status(o_status), .o_bucket(o_bucket), .o_slot(o_slot)
    );
endmodule

FILE: dv/string_hash_dictionary_core_tb.sv
`timescale 1ns / 1ps
// Testbench for string_hash_dictionary_core: directed and random words against
// a behavioral copy of the dictionary, under sender idle gaps and register changes.
// Depends on shd_pkg and the core RTL.
module string_hash_dictionary_core_tb;
    import shd_pkg::*;

    localparam int NBKT     = 256;
    localparam int NSLOT    = 8;
    localparam int MAXLEN   = 16;
    localparam int WD_LIMIT = 6000;
    localparam int SETTLE   = 500;

    typedef struct {
        logic [2:0] status;
        logic [7:0] bucket;
        logic [2:0] slot;
    } t_dict_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_kind = 1'b0;
    logic [7:0]  i_char_code = '0;
    logic        i_last_char = 1'b0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [7:0]  o_bucket;
    logic [2:0]  o_slot;

    string_hash_dictionary_core dut (.*);

    always #5 i_clk = ~i_clk;

    // dictionary predictor state
    int        mod_reg = 251;
    int        mult_reg = 31;
    logic [7:0] cur_chars [MAXLEN];
    int        cur_len = 0;
    int        hash_acc = 0;
    int        pow_acc = 1;
    int        fill_cnt [NBKT];
    logic [7:0] kept_chars [NBKT*NSLOT][MAXLEN];
    int        kept_len [NBKT*NSLOT];

    t_dict_res expected_q [$];
    int errors = 0;
    int chars_sent = 0;
    int words_done = 0;
    int status_seen [6];
    int idle_pct = 0;
    int idle_cnt = 0;

    // random word vocabulary, reused to hit duplicates and found words
    logic [7:0] vocab [64][20];
    int         vocab_len [64];
    int         vocab_n = 0;

    function automatic bit word_matches(int e);
        if (kept_len[e] != cur_len) return 0;
        for (int k = 0; k < cur_len; k++)
            if (kept_chars[e][k] != cur_chars[k]) return 0;
        return 1;
    endfunction

    function automatic bit fold_char(bit kind, logic [7:0] ch, bit lst,
                                     output t_dict_res r);
        int p, term, b, fill, s, e;
        bit hit;
        p = mod_reg;
        if (p < 1) p = 1;
        if (p > 256) p = 256;
        term = (int'(ch) * (pow_acc % p)) % p;
        hash_acc = ((hash_acc % p) + term) % p;
        pow_acc = ((pow_acc % p) * (mult_reg % p)) % p;
        if (cur_len < MAXLEN) cur_chars[cur_len] = ch;
        if (cur_len <= MAXLEN) cur_len++;
        if (!lst) return 0;
        b = hash_acc % p;
        r.status = ST_ABSENT;
        r.bucket = b[7:0];
        r.slot = 3'd0;
        if (cur_len > MAXLEN) begin
            r.status = ST_TOO_LONG;
        end else begin
            fill = fill_cnt[b];
            hit = 0;
            s = 0;
            while (s < fill && !hit) begin
                if (word_matches(b*NSLOT + s)) hit = 1;
                else s++;
            end
            if (kind) begin
                r.status = hit ? ST_FOUND : ST_ABSENT;
                if (hit) r.slot = s[2:0];
            end else if (hit) begin
                r.status = ST_DUPLICATE;
                r.slot = s[2:0];
            end else if (fill >= NSLOT) begin
                r.status = ST_FULL;
            end else begin
                e = b*NSLOT + fill;
                for (int k = 0; k < cur_len; k++) kept_chars[e][k] = cur_chars[k];
                kept_len[e] = cur_len;
                fill_cnt[b] = fill + 1;
                r.status = ST_INSERTED;
                r.slot = fill[2:0];
            end
        end
        cur_len = 0;
        hash_acc = 0;
        pow_acc = 1;
        return 1;
    endfunction

    // one character word; called right after a rising edge
    task automatic send_char(bit kind, logic [7:0] ch, bit lst);
        t_dict_res r;
        start <= 1'b1;
        i_kind <= kind;
        i_char_code <= ch;
        i_last_char <= lst;
        do @(posedge i_clk); while (busy);
        chars_sent++;
        if (fold_char(kind, ch, lst, r)) expected_q = {expected_q, r};
        if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(7, 0) == 0 ? $urandom_range(120, 1)
                                               : $urandom_range(4, 1))
                @(posedge i_clk);
        end
    endtask

    task automatic send_word(logic [7:0] w [20], int len, bit kind);
        for (int i = 0; i < len; i++)
            send_char(i == len-1 ? kind : 1'($urandom), w[i], i == len-1);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MODULUS) mod_reg = data[8:0];
        else mult_reg = data;
    endtask

    task automatic text_word(string s, int extra, bit kind);
        logic [7:0] w [20];
        for (int i = 0; i < 20; i++) w[i] = i < s.len() ? s[i] : 8'(65 + i + extra);
        send_word(w, s.len() + extra, kind);
    endtask

    task automatic test_directed();
        logic [7:0] w [20];
        // every word in bucket 0: fill it, then overflow
        write_reg(CFG_MODULUS, 16'd1);
        write_reg(CFG_MULTIPLIER, 16'd0);
        for (int i = 0; i < 8; i++) begin
            w[0] = 8'(i == 0 ? 0 : i == 1 ? 255 : i);
            send_word(w, 1, 1'b0);
        end
        w[0] = 8'd200;
        send_word(w, 1, 1'b0);          // bucket full
        w[0] = 8'd255;
        send_word(w, 1, 1'b0);          // duplicate
        send_word(w, 1, 1'b1);          // found
        w[0] = 8'd201;
        send_word(w, 1, 1'b1);          // absent
        write_reg(CFG_MODULUS, 16'hFE00); // modulus 0
        write_reg(CFG_MULTIPLIER, 16'hFFFF);
        text_word("q", 16, 1'b0);       // 17 chars, too long on insert
        text_word("q", 17, 1'b1);       // too long on query
        text_word("abcdefghijklmnop", 0, 1'b0); // exactly max length
        write_reg(CFG_MODULUS, 16'h01FF); // above 256
        text_word("zz", 0, 1'b0);
        text_word("zz", 0, 1'b1);
        // register change in the middle of a word
        send_char(1'b0, 8'h5A, 1'b0);
        write_reg(CFG_MODULUS, 16'd256);
        write_reg(CFG_MULTIPLIER, 16'd31);
        send_char(1'b1, 8'hA5, 1'b0);
        send_char(1'b0, 8'h3C, 1'b1);
        drain();
    endtask

    task automatic test_random(int pct, int items, int md, int ml);
        logic [7:0] w [20];
        int len, v;
        idle_pct = pct;
        write_reg(CFG_MODULUS, 16'(md) | 16'($urandom_range(127, 0) << 9));
        write_reg(CFG_MULTIPLIER, 16'(ml));
        while (chars_sent < items) begin
            if (vocab_n > 0 && $urandom_range(1, 0)) begin
                v = $urandom_range(vocab_n - 1, 0);
                send_word(vocab[v], vocab_len[v], 1'($urandom));
            end else begin
                len = $urandom_range(9, 0) == 0 ? $urandom_range(18, 14)
                                                : $urandom_range(5, 1);
                for (int i = 0; i < 20; i++) w[i] = 8'($urandom);
                if (vocab_n < 64) begin
                    v = vocab_n;
                    vocab_n++;
                end else begin
                    v = $urandom_range(63, 0);
                end
                vocab[v] = w;
                vocab_len[v] = len;
                send_word(w, len, 1'($urandom));
            end
        end
        drain();
        idle_pct = 0;
    endtask

    always @(posedge i_clk) begin
        t_dict_res x;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word: status %0d bucket %0d slot %0d",
                         $time, o_status, o_bucket, o_slot);
                errors++;
            end else begin
                x = expected_q.pop_front();
                words_done++;
                if (o_status < 6) status_seen[o_status]++;
                if (o_status !== x.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, x.status, o_status);
                    errors++;
                end
                if (o_bucket !== x.bucket) begin
                    $display("%0t: bucket expected %0d actual %0d", $time, x.bucket, o_bucket);
                    errors++;
                end
                if (o_slot !== x.slot) begin
                    $display("%0t: slot expected %0d actual %0d", $time, x.slot, o_slot);
                    errors++;
                end
            end
        end
    end

    // stall watchdog: cycles without any accepted character, config or result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WD_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NBKT; i++) fill_cnt[i] = 0;
        for (int i = 0; i < 6; i++) status_seen[i] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(33, 700, $urandom_range(12, 2), $urandom_range(65535, 0));
        test_random(56, 1350, $urandom_range(511, 200), 65535);
        test_random(0, 1950, $urandom_range(256, 1), $urandom_range(65535, 0));
        if (expected_q.size() > 0) begin
            $display("%0t: %0d words never arrived", $time, expected_q.size());
            errors++;
        end
        $display("Sent %0d characters, checked %0d words (ins %0d dup %0d full %0d",
                 chars_sent, words_done, status_seen[0], status_seen[1], status_seen[2]);
        $display("  long %0d found %0d absent %0d), %0d errors",
                 status_seen[3], status_seen[4], status_seen[5], errors);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
